// File: hw/rtl/dos_pkg.sv
`default_nettype none
package dos_pkg;

    localparam int DATA_W        = 32;
    localparam int MU_FB         = 16;
    localparam int MU_W          = 18;
    localparam int LEG_W         = 21;
    localparam int COEF_W        = 24;
    localparam int SUM_W         = 56;
    localparam int Q_W           = SUM_W - (MU_FB + 1);
    localparam int C_W           = MU_W + 1;
    localparam int NUM_W         = 40;
    localparam int DEN_W         = 32;
    localparam int WP_W          = 24;
    localparam int MAX_ORDER     = 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int ADDR_W        = 5;

    // register indexes (byte address bits [4:2])
    localparam logic [2:0] REG_METHOD       = 3'd0;
    localparam logic [2:0] REG_MU           = 3'd1;
    localparam logic [2:0] REG_WEIGHT       = 3'd2;
    localparam logic [2:0] REG_SOURCE_ORDER = 3'd3;
    localparam logic [2:0] REG_FLUX_ORDER   = 3'd4;

    typedef struct packed {
        logic                       method;
        logic signed [MU_W-1:0]     mu;
        logic [MU_W-1:0]            weight;
        logic [1:0]                 source_order;
        logic [1:0]                 flux_order;
    } dos_cfg_t;

    typedef struct packed {
        logic                       first_cell;
        logic signed [DATA_W-1:0]   boundary_psi;
        logic [DATA_W-2:0]          sigma_t_dx;
        logic signed [DATA_W-1:0]   src_m0;
        logic signed [DATA_W-1:0]   src_m1;
        logic signed [DATA_W-1:0]   src_m2;
        logic signed [DATA_W-1:0]   old_flux_m0;
        logic signed [DATA_W-1:0]   old_flux_m1;
        logic signed [DATA_W-1:0]   old_flux_m2;
        logic signed [DATA_W-1:0]   scat_dx_m0;
        logic signed [DATA_W-1:0]   scat_dx_m1;
        logic signed [DATA_W-1:0]   scat_dx_m2;
    } dos_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   center_flux;
        logic signed [DATA_W-1:0]   contrib_m0;
        logic signed [DATA_W-1:0]   contrib_m1;
        logic signed [DATA_W-1:0]   contrib_m2;
        logic signed [DATA_W-1:0]   edge_out;
    } dos_out_t;

    // one classified cell handed from front to back
    typedef struct packed {
        logic                       first_cell;
        logic signed [DATA_W-1:0]   boundary_psi;
        logic [DATA_W-2:0]          sigma_t_dx;
        logic signed [Q_W-1:0]      q;
        logic signed [LEG_W-1:0]    leg2;
    } dos_qentry_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [71:0] v);
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        hi = 72'sd2147483647;
        lo = -72'sd2147483648;
        if (v > hi)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < lo)
        begin
            return 32'sh80000000;
        end
        return DATA_W'(v);
    endfunction

    function automatic logic [1:0] eff_order(input logic [1:0] r);
        return (r > 2'(MAX_ORDER)) ? 2'(MAX_ORDER) : r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/discrete_ordinates_cell_sweep.sv
`default_nettype none
// One-dimensional discrete-ordinates sweep cell. Each transfer on the item
// channel is one spatial cell for the ordinate set up in the registers (mu,
// weight, method, source and flux order); each cell gives exactly one transfer
// on the result channel: the center angular flux, the weighted moment
// contributions w*P_n(mu)*center and the outgoing edge flux, which the block
// also keeps as the incoming edge of the next cell unless first_cell selects
// boundary_psi. Data are signed Q15.16, mu signed Q1.16, weight unsigned
// Q2.16. A front unit forms the scattering source q with one shared
// multiplier, a two-entry queue decouples it from the back unit, which runs
// a radix-2 restoring divider for the center flux. The back unit sets the
// cell rate and spends one quotient bit per cycle in the divider. Write the
// registers only while no cell is in flight.
module discrete_ordinates_cell_sweep
    import dos_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire dos_in_t           item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output dos_out_t               result
);

    dos_cfg_t    cfg_reg;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    dos_qentry_t q_in;
    dos_qentry_t q_head;
    logic        wr_en;

    // APB: no wait states; commit the register in the access phase
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.method       <= 1'b0;
            cfg_reg.mu           <= MU_W'(65536);
            cfg_reg.weight       <= MU_W'(65536);
            cfg_reg.source_order <= 2'd0;
            cfg_reg.flux_order   <= 2'd0;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_METHOD:       cfg_reg.method       <= pwdata[0];
                REG_MU:           cfg_reg.mu           <= pwdata[MU_W-1:0];
                REG_WEIGHT:       cfg_reg.weight       <= pwdata[MU_W-1:0];
                REG_SOURCE_ORDER: cfg_reg.source_order <= pwdata[1:0];
                REG_FLUX_ORDER:   cfg_reg.flux_order   <= pwdata[1:0];
                default:
                begin
                end
            endcase
        end
    end

    // read back; sign-extend mu so software sees the signed value
    always_comb
    begin
        unique case (paddr[4:2])
            REG_METHOD:       prdata = {31'd0, cfg_reg.method};
            REG_MU:           prdata = 32'(cfg_reg.mu);
            REG_WEIGHT:       prdata = {14'd0, cfg_reg.weight};
            REG_SOURCE_ORDER: prdata = {30'd0, cfg_reg.source_order};
            REG_FLUX_ORDER:   prdata = {30'd0, cfg_reg.flux_order};
            default:          prdata = '0;
        endcase
    end

    // front: take the cell, fold source and scattering moments into q
    dos_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full)
    );

    // hold classified cells so the front can move on while the back divides
    dos_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // back: edge recurrence, division, contributions, output register
    dos_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (q_head),
        .empty        (q_empty),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire

// File: hw/rtl/dos_queue.sv
`default_nettype none
module dos_queue
    import dos_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire dos_qentry_t push_entry,
    input  wire logic        pop,
    output dos_qentry_t      head,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dos_qentry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/dos_front.sv
`default_nettype none
module dos_front
    import dos_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dos_cfg_t cfg,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire dos_in_t  item,
    output logic          push,
    output dos_qentry_t   push_entry,
    input  wire logic     full
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_PROD = 3'd2;
    localparam logic [2:0] ST_TERM = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_PUSH = 3'd5;

    logic [2:0]               state_reg;
    dos_in_t                  item_reg;
    logic [1:0]               l_reg;
    logic [34:0]              sq_reg;
    logic signed [63:0]       prod_reg;
    logic signed [DATA_W-1:0] t_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [65:0]       mul_p;
    logic signed [37:0]       leg2_full;
    logic signed [LEG_W-1:0]  leg2;
    logic signed [COEF_W-1:0] coef;
    logic signed [DATA_W-1:0] src_sel;
    logic signed [DATA_W-1:0] old_sel;
    logic signed [DATA_W-1:0] scat_sel;
    logic [1:0]               so;

    assign so = eff_order(cfg.source_order);

    // P2 = (3 mu^2 - 1) / 2 in Q.16
    assign leg2_full = $signed({3'b000, sq_reg}) * 38'sd3 - (38'sd1 <<< (2 * MU_FB));
    assign leg2      = LEG_W'(leg2_full >>> (MU_FB + 1));

    always_comb
    begin
        unique case (l_reg)
            2'd0:
            begin
                coef     = COEF_W'(65536);
                src_sel  = item_reg.src_m0;
                old_sel  = item_reg.old_flux_m0;
                scat_sel = item_reg.scat_dx_m0;
            end
            2'd1:
            begin
                coef     = COEF_W'(cfg.mu) * COEF_W'(3);
                src_sel  = item_reg.src_m1;
                old_sel  = item_reg.old_flux_m1;
                scat_sel = item_reg.scat_dx_m1;
            end
            2'd2:
            begin
                coef     = COEF_W'(leg2) * COEF_W'(5);
                src_sel  = item_reg.src_m2;
                old_sel  = item_reg.old_flux_m2;
                scat_sel = item_reg.scat_dx_m2;
            end
            default:
            begin
                coef     = '0;
                src_sel  = '0;
                old_sel  = '0;
                scat_sel = '0;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_SQ:
            begin
                mul_a = 33'(cfg.mu);
                mul_b = 33'(cfg.mu);
            end
            ST_ACC:
            begin
                mul_a = 33'(coef);
                mul_b = 33'(t_reg);
            end
            default:
            begin
                mul_a = 33'(old_sel);
                mul_b = 33'(scat_sel);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign item_stall       = (state_reg != ST_IDLE);
    assign push             = (state_reg == ST_PUSH);
    assign push_entry.first_cell   = item_reg.first_cell;
    assign push_entry.boundary_psi = item_reg.boundary_psi;
    assign push_entry.sigma_t_dx   = item_reg.sigma_t_dx;
    assign push_entry.q            = Q_W'(sum_reg >>> (MU_FB + 1));
    assign push_entry.leg2         = leg2;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                item_reg <= item;
            end
            ST_SQ:
            begin
                sq_reg  <= mul_p[34:0];
                sum_reg <= '0;
            end
            ST_PROD:
            begin
                prod_reg <= mul_p[63:0];
            end
            ST_TERM:
            begin
                t_reg <= sat32(72'(src_sel) + 72'(prod_reg >>> FRAC_BITS));
            end
            ST_ACC:
            begin
                sum_reg <= sum_reg + SUM_W'(mul_p);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            l_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    l_reg     <= '0;
                    state_reg <= ST_PROD;
                end
                ST_PROD:
                begin
                    state_reg <= ST_TERM;
                end
                ST_TERM:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (l_reg == so)
                    begin
                        state_reg <= ST_PUSH;
                    end
                    else
                    begin
                        l_reg     <= l_reg + 1'b1;
                        state_reg <= ST_PROD;
                    end
                end
                ST_PUSH:
                begin
                    if (!full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/dos_back.sv
`default_nettype none
module dos_back
    import dos_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dos_cfg_t    cfg,
    input  wire dos_qentry_t head,
    input  wire logic        empty,
    output logic             pop,
    output logic             result_valid,
    input  wire logic        result_stall,
    output dos_out_t         result
);

    localparam int DVD_W = NUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int SHL   = (FRAC_BITS >= MU_FB) ? FRAC_BITS - MU_FB : 0;
    localparam int SHR   = (FRAC_BITS <  MU_FB) ? MU_FB - FRAC_BITS : 0;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NUM  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_WP   = 3'd5;
    localparam logic [2:0] ST_CON  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]               state_reg;
    dos_qentry_t              entry_reg;
    logic signed [DATA_W-1:0] edge_reg;
    logic signed [DATA_W-1:0] edge_psi_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [DVD_W-1:0]         quo_reg;
    logic [DEN_W:0]           rem_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [DATA_W-1:0] center_reg;
    logic signed [DATA_W-1:0] next_reg;
    logic signed [WP_W-1:0]   wp_reg;
    logic signed [DATA_W-1:0] contrib_reg [3];
    logic [1:0]               l_reg;
    logic                     out_valid_reg;
    dos_out_t                 out_reg;

    logic [MU_W-1:0]          a_abs;
    logic [C_W-1:0]           c;
    logic [DEN_W-1:0]         c_frac;
    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [65:0]       mul_p;
    logic signed [LEG_W-1:0]  leg_sel;
    logic [NUM_W-1:0]         num_mag;
    logic [DEN_W:0]           rem_sh;
    logic                     rem_ge;
    logic [DVD_W-32:0]        quo_hi;
    logic signed [DATA_W-1:0] center_c;
    logic [1:0]               fo;
    logic                     out_free;

    assign fo       = eff_order(cfg.flux_order);
    assign a_abs    = cfg.mu[MU_W-1] ? MU_W'(-cfg.mu) : MU_W'(cfg.mu);
    assign c        = cfg.method ? {1'b0, a_abs} : {a_abs, 1'b0};
    assign c_frac   = (DEN_W'(c) << SHL) >> SHR;
    assign num_mag  = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign rem_sh   = {rem_reg[DEN_W-1:0], quo_reg[DVD_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, den_reg});
    assign quo_hi   = quo_reg[DVD_W-1:31];
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        unique case (l_reg)
            2'd0:    leg_sel = LEG_W'(65536);
            2'd1:    leg_sel = LEG_W'(cfg.mu);
            2'd2:    leg_sel = entry_reg.leg2;
            default: leg_sel = '0;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_NUM:
            begin
                mul_a = 33'($signed({1'b0, c}));
                mul_b = 33'(edge_reg);
            end
            ST_WP:
            begin
                mul_a = 33'($signed({1'b0, cfg.weight}));
                mul_b = 33'(leg_sel);
            end
            default:
            begin
                mul_a = 33'(wp_reg);
                mul_b = 33'(center_reg);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // resolve sign, zero divisor and overflow of the quotient
    always_comb
    begin
        if (den_reg == '0)
        begin
            if (num_reg > 0)
            begin
                center_c = 32'sh7FFFFFFF;
            end
            else if (num_reg < 0)
            begin
                center_c = 32'sh80000000;
            end
            else
            begin
                center_c = '0;
            end
        end
        else if (num_reg[NUM_W-1])
        begin
            if ((quo_hi > 1) || ((quo_hi == 1) && (quo_reg[30:0] != '0)))
            begin
                center_c = 32'sh80000000;
            end
            else
            begin
                center_c = DATA_W'(-quo_reg[31:0]);
            end
        end
        else
        begin
            center_c = (quo_hi != '0) ? 32'sh7FFFFFFF : DATA_W'(quo_reg[31:0]);
        end
    end

    assign pop          = (state_reg == ST_IDLE) && !empty;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                entry_reg <= head;
                edge_reg  <= head.first_cell ? head.boundary_psi : edge_psi_reg;
            end
            ST_NUM:
            begin
                num_reg <= NUM_W'(mul_p >>> MU_FB) + NUM_W'(entry_reg.q);
                den_reg <= DEN_W'(entry_reg.sigma_t_dx) + c_frac;
            end
            ST_PREP:
            begin
                quo_reg <= {num_mag, {FRAC_BITS{1'b0}}};
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= rem_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                quo_reg <= {quo_reg[DVD_W-2:0], rem_ge};
            end
            ST_FIN:
            begin
                center_reg <= center_c;
                next_reg   <= cfg.method ? center_c
                                         : sat32(72'(center_c) * 72'sd2 - 72'(edge_reg));
            end
            ST_WP:
            begin
                wp_reg <= WP_W'(mul_p >>> MU_FB);
            end
            ST_CON:
            begin
                contrib_reg[l_reg] <= (l_reg <= fo) ? sat32(72'(mul_p >>> MU_FB)) : '0;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_reg.center_flux <= center_reg;
                    out_reg.contrib_m0  <= contrib_reg[0];
                    out_reg.contrib_m1  <= contrib_reg[1];
                    out_reg.contrib_m2  <= contrib_reg[2];
                    out_reg.edge_out    <= next_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            edge_psi_reg  <= '0;
            cnt_reg       <= '0;
            l_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // load a finished cell, else drop the result once it is taken
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        state_reg <= ST_NUM;
                    end
                end
                ST_NUM:
                begin
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    cnt_reg   <= CNT_W'(DVD_W);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    l_reg     <= '0;
                    state_reg <= ST_WP;
                end
                ST_WP:
                begin
                    state_reg <= ST_CON;
                end
                ST_CON:
                begin
                    if (l_reg == 2'd2)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        l_reg     <= l_reg + 1'b1;
                        state_reg <= ST_WP;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        edge_psi_reg <= next_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && (den_reg != '0)) |-> (rem_reg < {1'b0, den_reg}))
        else $error("divider remainder not below divisor");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && out_free) |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("finished cell not presented");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!empty && (state_reg == ST_IDLE)))
        else $error("queue popped outside idle");

endmodule
`default_nettype wire
